[hdl/region_switch_led_controller_top_macros.svh]
// Assertion macros for the region switch LED controller.
// Used by the top level; no other dependencies.
`ifndef REGION_SWITCH_LED_CONTROLLER_TOP_MACROS_SVH
`define REGION_SWITCH_LED_CONTROLLER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Condition a must be followed by condition b in the same cycle.
`define RSL_ASSERT_IMPLIES(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);
// Condition a must be followed by condition b in the next cycle.
`define RSL_ASSERT_NEXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);
`else
`define RSL_ASSERT_IMPLIES(lbl, a, b, msg)
`define RSL_ASSERT_NEXT(lbl, a, b, msg)
`endif
`endif

[hdl/rsl_pkg.sv]
// Shared types and constants of the region switch LED controller.
// No dependencies; imported by every module of the block.
package rsl_pkg;

    // Field widths.
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 24;
    localparam int PERIOD_W = CFG_W + 1;
    localparam int LIMIT_W  = PERIOD_W + 3;
    localparam int LEVEL_W  = 16;
    localparam int REGION_W = 2;
    localparam int MAP_W    = 6;
    localparam int CMD_W    = 3;
    localparam int IDX_W    = 3;
    localparam int BLINK_W  = 3;

    // Number of supported regions.
    localparam int REGIONS = 3;

    // Host command codes.
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SYNC   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SELECT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_COMMIT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESET  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_STATUS = 3'd5;

    // Sync request codes.
    localparam logic [1:0] SREQ_NONE  = 2'd0;
    localparam logic [1:0] SREQ_START = 2'd1;
    localparam logic [1:0] SREQ_STOP  = 2'd2;

    // LED modes.
    localparam logic [1:0] LED_STEADY  = 2'd0;
    localparam logic [1:0] LED_BLINK   = 2'd1;
    localparam logic [1:0] LED_BREATHE = 2'd2;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_LONG_PRESS = 3'd0;
    localparam logic [IDX_W-1:0] CFG_SYNC_PRESS = 3'd1;
    localparam logic [IDX_W-1:0] CFG_BLINK_DARK = 3'd2;
    localparam logic [IDX_W-1:0] CFG_BLINK_LIT  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_RESET_HOLD = 3'd4;
    localparam logic [IDX_W-1:0] CFG_FULL_LEVEL = 3'd5;
    localparam logic [IDX_W-1:0] CFG_PIN_MAP    = 3'd6;
    localparam logic [IDX_W-1:0] CFG_START      = 3'd7;

    // Configuration reset values.
    localparam logic [CFG_W-1:0]    RST_LONG_PRESS = 24'd1000000;
    localparam logic [CFG_W-1:0]    RST_SYNC_PRESS = 24'd3000000;
    localparam logic [CFG_W-1:0]    RST_BLINK_DARK = 24'd150000;
    localparam logic [CFG_W-1:0]    RST_BLINK_LIT  = 24'd150000;
    localparam logic [CFG_W-1:0]    RST_RESET_HOLD = 24'd100000;
    localparam logic [LEVEL_W-1:0]  RST_FULL_LEVEL = 16'd65535;
    localparam logic [MAP_W-1:0]    RST_PIN_MAP    = 6'd13;
    localparam logic [REGION_W-1:0] RST_START      = 2'd0;

    // Breathing waveform: ten bits of time from bit ten upward, folded at the midpoint.
    localparam int               BREATHE_LSB  = 10;
    localparam int               BREATHE_W    = 10;
    localparam logic [BREATHE_W-1:0] BREATHE_MASK = 10'd1023;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic do_button;
        logic do_led;
        logic div_start;
        logic do_finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } ctrl_status_t;

endpackage

[hdl/rsl_div.sv]
// Restoring remainder unit: one dividend bit per cycle.
// Depends on rsl_pkg for the time and period widths.
module rsl_div
    import rsl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [TIME_W-1:0]   dividend,
    input  logic [PERIOD_W-1:0] divisor,
    output logic                done,
    output logic [PERIOD_W-1:0] remainder
);

    localparam int CNT_W = $clog2(TIME_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_W - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [TIME_W-1:0]   shift_reg, shift_next;
    logic [PERIOD_W:0]   trial;

    // One shift and conditional subtract per cycle.
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        trial      = {rem_reg, shift_reg[TIME_W-1]};
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            rem_next   = '0;
            shift_next = dividend;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
                rem_next = PERIOD_W'(trial - {1'b0, divisor});
            else
                rem_next = trial[PERIOD_W-1:0];
            shift_next = {shift_reg[TIME_W-2:0], 1'b0};
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[hdl/rsl_ctrl.sv]
// Sequencing state machine of the region switch LED controller.
// Depends on rsl_pkg for the command and status structs.
module rsl_ctrl
    import rsl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUTTON,
        S_LED,
        S_CHECK,
        S_DIV,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_BUTTON;
            S_BUTTON: state_next = S_LED;
            S_LED:    state_next = S_CHECK;
            S_CHECK:  state_next = status.need_div ? S_DIV : S_FINISH;
            S_DIV:    if (status.div_done) state_next = S_FINISH;
            S_FINISH: if (status.out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // State and the registered input ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == S_IDLE);
        end
    end

    // Commands decoded from the state.
    always_comb
    begin
        cmd.load_item = in_valid && in_ready_reg;
        cmd.do_button = (state_reg == S_BUTTON);
        cmd.do_led    = (state_reg == S_LED);
        cmd.div_start = (state_reg == S_CHECK) && status.need_div;
        cmd.do_finish = (state_reg == S_FINISH) && status.out_free;
    end

    assign in_ready = in_ready_reg;

endmodule

[hdl/rsl_dp.sv]
// Datapath of the region switch LED controller: configuration, press
// tracking, LED state and the result register. Depends on rsl_pkg, rsl_div.
module rsl_dp
    import rsl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [TIME_W-1:0]   time_us,
    input  logic                button_down,
    input  logic                sync_active,
    input  logic [REGION_W-1:0] region_pick,
    input  ctrl_cmd_t           ctrl,
    output ctrl_status_t        status,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [LEVEL_W-1:0]  led_level,
    output logic                lang_pin,
    output logic                fmt_pin,
    output logic                reset_drive,
    output logic [1:0]          sync_request,
    output logic                status_valid,
    output logic [REGION_W-1:0] active_region,
    output logic [REGION_W-1:0] chosen_region
);

    localparam logic [REGION_W:0] NUM_REGIONS = (REGION_W + 1)'(REGIONS);

    // Configuration registers.
    logic [CFG_W-1:0]    long_reg, long_next;
    logic [CFG_W-1:0]    sync_reg, sync_next;
    logic [CFG_W-1:0]    dark_reg, dark_next;
    logic [CFG_W-1:0]    lit_reg, lit_next;
    logic [CFG_W-1:0]    hold_reg, hold_next;
    logic [LEVEL_W-1:0]  full_reg, full_next;
    logic [MAP_W-1:0]    map_reg, map_next;

    // Block state.
    logic [REGION_W-1:0] active_reg, active_next;
    logic [REGION_W-1:0] chosen_reg, chosen_next;
    logic                syncing_reg, syncing_next;
    logic                sent_reg, sent_next;
    logic                was_down_reg, was_down_next;
    logic [TIME_W-1:0]   press_start_reg, press_start_next;
    logic [1:0]          mode_reg, mode_next;
    logic [TIME_W-1:0]   mark_reg, mark_next;
    logic [BLINK_W-1:0]  blinks_reg, blinks_next;
    logic [TIME_W-1:0]   reset_end_reg, reset_end_next;
    logic                reset_on_reg, reset_on_next;
    logic [LEVEL_W-1:0]  held_reg, held_next;
    logic                ovalid_reg, ovalid_next;

    // Item and working registers.
    logic [CMD_W-1:0]    cmd_reg;
    logic [TIME_W-1:0]   now_reg;
    logic                btn_reg;
    logic                sact_reg;
    logic [REGION_W-1:0] pick_reg;
    logic [1:0]          sreq_reg, sreq_next;
    logic [TIME_W-1:0]   delta_reg, delta_next;
    logic [LIMIT_W-1:0]  limit_reg, limit_next;

    // Result registers.
    logic [LEVEL_W-1:0]  o_level_reg, o_level_next;
    logic                o_lang_reg, o_lang_next;
    logic                o_fmt_reg, o_fmt_next;
    logic                o_rst_reg, o_rst_next;
    logic [1:0]          o_sreq_reg, o_sreq_next;
    logic                o_stat_reg, o_stat_next;
    logic [REGION_W-1:0] o_active_reg, o_active_next;
    logic [REGION_W-1:0] o_chosen_reg, o_chosen_next;

    // Intermediate values.
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] div_rem;
    logic [PERIOD_W-1:0] phase;
    logic                div_done;
    logic                expired;
    logic [TIME_W-1:0]   press_len;
    logic [TIME_W-1:0]   hold_start;
    logic [TIME_W-1:0]   held_len;
    logic [TIME_W-1:0]   since_end;
    logic [REGION_W:0]   step_region;
    logic [REGION_W-1:0] next_region;
    logic [BREATHE_W-1:0] wave;
    logic [BREATHE_W-1:0] fold;
    logic [7:0]          half;
    logic [REGION_W-1:0] start_clamp;
    logic [MAP_W+1:0]    map_ext;

    assign period  = {1'b0, dark_reg} + {1'b0, lit_reg};
    assign expired = delta_reg > {{(TIME_W - LIMIT_W){1'b0}}, limit_reg};

    // Remainder of the elapsed blink time by the blink period.
    rsl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctrl.div_start),
        .dividend  (delta_reg),
        .divisor   (period),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        status.need_div = (mode_reg == LED_BLINK) && !expired && (period != '0);
        status.div_done = div_done;
        status.out_free = !ovalid_reg || out_ready;
    end

    // Next values of the state, step by step as the controller commands.
    always_comb
    begin
        long_next        = long_reg;
        sync_next        = sync_reg;
        dark_next        = dark_reg;
        lit_next         = lit_reg;
        hold_next        = hold_reg;
        full_next        = full_reg;
        map_next         = map_reg;
        active_next      = active_reg;
        chosen_next      = chosen_reg;
        syncing_next     = syncing_reg;
        sent_next        = sent_reg;
        was_down_next    = was_down_reg;
        press_start_next = press_start_reg;
        mode_next        = mode_reg;
        mark_next        = mark_reg;
        blinks_next      = blinks_reg;
        reset_end_next   = reset_end_reg;
        reset_on_next    = reset_on_reg;
        held_next        = held_reg;
        sreq_next        = sreq_reg;
        delta_next       = delta_reg;
        limit_next       = limit_reg;

        press_len   = now_reg - press_start_reg;
        hold_start  = was_down_reg ? press_start_reg : now_reg;
        held_len    = now_reg - hold_start;
        since_end   = now_reg - reset_end_reg;
        step_region = {1'b0, chosen_reg} + 1'b1;
        next_region = (step_region >= NUM_REGIONS) ? '0 : step_region[REGION_W-1:0];
        wave        = now_reg[BREATHE_LSB +: BREATHE_W];
        fold        = wave[BREATHE_W-1] ? (BREATHE_MASK - wave) : wave;
        half        = fold[8:1];
        phase       = (period != '0) ? div_rem : '0;
        start_clamp = ({1'b0, cfg_data[REGION_W-1:0]} < NUM_REGIONS) ?
                      cfg_data[REGION_W-1:0] : '0;

        // Reset pulse expiry and button handling.
        if (ctrl.do_button)
        begin
            sreq_next = SREQ_NONE;
            if (reset_on_reg && !since_end[TIME_W-1])
                reset_on_next = 1'b0;
            if (was_down_reg && !btn_reg)
            begin
                if (syncing_reg)
                    sreq_next = SREQ_STOP;
                else if (sent_reg)
                    sent_next = 1'b0;
                else if (press_len < {{(TIME_W - CFG_W){1'b0}}, long_reg})
                begin
                    active_next    = chosen_reg;
                    reset_on_next  = 1'b1;
                    reset_end_next = now_reg + {{(TIME_W - CFG_W){1'b0}}, hold_reg};
                end
                else
                begin
                    chosen_next = next_region;
                    mode_next   = LED_BLINK;
                    blinks_next = BLINK_W'(next_region) + 1'b1;
                    mark_next   = now_reg;
                end
            end
            else if (btn_reg)
            begin
                press_start_next = hold_start;
                if ((held_len > {{(TIME_W - CFG_W){1'b0}}, sync_reg}) && !sent_reg)
                begin
                    sreq_next = syncing_reg ? SREQ_STOP : SREQ_START;
                    sent_next = 1'b1;
                end
            end
            was_down_next = btn_reg;
        end

        // Blink timing operands.
        if (ctrl.do_led)
        begin
            delta_next = now_reg - mark_reg;
            limit_next = LIMIT_W'({3'b000, period}) * LIMIT_W'(blinks_reg);
        end

        // LED update, then the host command.
        if (ctrl.do_finish)
        begin
            if (mode_reg == LED_BLINK)
            begin
                if (expired)
                begin
                    mode_next = syncing_reg ? LED_BREATHE : LED_STEADY;
                    if (!syncing_reg)
                        held_next = full_reg;
                    blinks_next = '0;
                    mark_next   = now_reg;
                end
                else
                    held_next = (phase > {1'b0, dark_reg}) ? full_reg : '0;
            end
            else if (mode_reg == LED_BREATHE)
                held_next = {{(LEVEL_W - 8){1'b0}}, half} * {{(LEVEL_W - 8){1'b0}}, half};
            else
            begin
                mode_next = LED_STEADY;
                held_next = full_reg;
            end

            unique case (cmd_reg)
                CMD_SYNC:
                begin
                    syncing_next = sact_reg;
                    mode_next    = sact_reg ? LED_BREATHE : LED_STEADY;
                    blinks_next  = '0;
                    mark_next    = now_reg;
                end
                CMD_SELECT:
                begin
                    if ({1'b0, pick_reg} < NUM_REGIONS)
                    begin
                        chosen_next = pick_reg;
                        mode_next   = LED_BLINK;
                        blinks_next = BLINK_W'(pick_reg) + 1'b1;
                        mark_next   = now_reg;
                    end
                end
                CMD_COMMIT:
                    active_next = chosen_reg;
                CMD_RESET:
                begin
                    active_next    = chosen_reg;
                    reset_on_next  = 1'b1;
                    reset_end_next = now_reg + {{(TIME_W - CFG_W){1'b0}}, hold_reg};
                end
                default:
                begin
                end
            endcase
        end

        // Configuration writes; the start region also loads both regions.
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LONG_PRESS: long_next = cfg_data;
                CFG_SYNC_PRESS: sync_next = cfg_data;
                CFG_BLINK_DARK: dark_next = cfg_data;
                CFG_BLINK_LIT:  lit_next  = cfg_data;
                CFG_RESET_HOLD: hold_next = cfg_data;
                CFG_FULL_LEVEL: full_next = cfg_data[LEVEL_W-1:0];
                CFG_PIN_MAP:    map_next  = cfg_data[MAP_W-1:0];
                CFG_START:
                begin
                    active_next = start_clamp;
                    chosen_next = start_clamp;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result of the item, taken from the final state.
    always_comb
    begin
        map_ext       = {2'b00, map_reg};
        o_level_next  = held_next;
        o_lang_next   = map_ext[{active_next, 1'b0}];
        o_fmt_next    = map_ext[{active_next, 1'b1}];
        o_rst_next    = reset_on_next;
        o_sreq_next   = sreq_reg;
        o_stat_next   = (cmd_reg == CMD_STATUS);
        o_active_next = active_next;
        o_chosen_next = chosen_next;
        if (ctrl.do_finish)
            ovalid_next = 1'b1;
        else if (out_ready)
            ovalid_next = 1'b0;
        else
            ovalid_next = ovalid_reg;
    end

    // Configuration and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_reg        <= RST_LONG_PRESS;
            sync_reg        <= RST_SYNC_PRESS;
            dark_reg        <= RST_BLINK_DARK;
            lit_reg         <= RST_BLINK_LIT;
            hold_reg        <= RST_RESET_HOLD;
            full_reg        <= RST_FULL_LEVEL;
            map_reg         <= RST_PIN_MAP;
            active_reg      <= RST_START;
            chosen_reg      <= RST_START;
            syncing_reg     <= 1'b0;
            sent_reg        <= 1'b0;
            was_down_reg    <= 1'b0;
            press_start_reg <= '0;
            mode_reg        <= LED_STEADY;
            mark_reg        <= '0;
            blinks_reg      <= '0;
            reset_end_reg   <= '0;
            reset_on_reg    <= 1'b0;
            held_reg        <= RST_FULL_LEVEL;
            ovalid_reg      <= 1'b0;
        end
        else
        begin
            long_reg        <= long_next;
            sync_reg        <= sync_next;
            dark_reg        <= dark_next;
            lit_reg         <= lit_next;
            hold_reg        <= hold_next;
            full_reg        <= full_next;
            map_reg         <= map_next;
            active_reg      <= active_next;
            chosen_reg      <= chosen_next;
            syncing_reg     <= syncing_next;
            sent_reg        <= sent_next;
            was_down_reg    <= was_down_next;
            press_start_reg <= press_start_next;
            mode_reg        <= mode_next;
            mark_reg        <= mark_next;
            blinks_reg      <= blinks_next;
            reset_end_reg   <= reset_end_next;
            reset_on_reg    <= reset_on_next;
            held_reg        <= held_next;
            ovalid_reg      <= ovalid_next;
        end
    end

    // Item capture, working values and result payload.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            cmd_reg  <= cmd;
            now_reg  <= time_us;
            btn_reg  <= button_down;
            sact_reg <= sync_active;
            pick_reg <= region_pick;
        end
        sreq_reg  <= sreq_next;
        delta_reg <= delta_next;
        limit_reg <= limit_next;
        if (ctrl.do_finish)
        begin
            o_level_reg  <= o_level_next;
            o_lang_reg   <= o_lang_next;
            o_fmt_reg    <= o_fmt_next;
            o_rst_reg    <= o_rst_next;
            o_sreq_reg   <= o_sreq_next;
            o_stat_reg   <= o_stat_next;
            o_active_reg <= o_active_next;
            o_chosen_reg <= o_chosen_next;
        end
    end

    // Result channel outputs.
    assign out_valid     = ovalid_reg;
    assign led_level     = o_level_reg;
    assign lang_pin      = o_lang_reg;
    assign fmt_pin       = o_fmt_reg;
    assign reset_drive   = o_rst_reg;
    assign sync_request  = o_sreq_reg;
    assign status_valid  = o_stat_reg;
    assign active_region = o_active_reg;
    assign chosen_region = o_chosen_reg;

endmodule

[hdl/region_switch_led_controller_top.sv]
// Region switch LED controller: an item is taken while the sequencer is idle,
// passes the button, LED and check states and, while the LED blinks, the
// remainder unit that finds the blink phase; its result is registered once the
// output register is free. The next item can be taken in the cycle after the
// result enters the output register, so items do not overlap. Reset is
// asynchronous, active low, and restores the state and configuration defaults.
`include "region_switch_led_controller_top_macros.svh"
module region_switch_led_controller_top
    import rsl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [TIME_W-1:0]   time_us,
    input  logic                button_down,
    input  logic                sync_active,
    input  logic [REGION_W-1:0] region_pick,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [LEVEL_W-1:0]  led_level,
    output logic                lang_pin,
    output logic                fmt_pin,
    output logic                reset_drive,
    output logic [1:0]          sync_request,
    output logic                status_valid,
    output logic [REGION_W-1:0] active_region,
    output logic [REGION_W-1:0] chosen_region
);

    ctrl_cmd_t    ctrl_cmd;
    ctrl_status_t ctrl_status;

    // Configuration transfers are always taken.
    assign cfg_ready = 1'b1;

    // Sequencer.
    rsl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (ctrl_status),
        .cmd      (ctrl_cmd)
    );

    // Datapath.
    rsl_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .time_us       (time_us),
        .button_down   (button_down),
        .sync_active   (sync_active),
        .region_pick   (region_pick),
        .ctrl          (ctrl_cmd),
        .status        (ctrl_status),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .led_level     (led_level),
        .lang_pin      (lang_pin),
        .fmt_pin       (fmt_pin),
        .reset_drive   (reset_drive),
        .sync_request  (sync_request),
        .status_valid  (status_valid),
        .active_region (active_region),
        .chosen_region (chosen_region)
    );

    // Checks on sequencing and the result.
    `RSL_ASSERT_NEXT(a_one_item_at_a_time, in_valid && in_ready, !in_ready, "input while busy")
    `RSL_ASSERT_IMPLIES(a_finish_room, ctrl_cmd.do_finish, !out_valid || out_ready, "result lost")
    `RSL_ASSERT_IMPLIES(a_sync_code, out_valid, sync_request <= SREQ_STOP, "bad sync request")
    `RSL_ASSERT_NEXT(a_div_latency, ctrl_cmd.div_start, !ctrl_status.div_done, "early remainder")

endmodule

[tb/region_switch_led_checker.sv]
// Checker for the region switch LED controller: watches the register, item and
// result channels, predicts every result and compares it field by field.
// Depends on rsl_pkg for widths, command codes and register defaults.
module region_switch_led_checker
    import rsl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [TIME_W-1:0]   time_us,
    input  logic                button_down,
    input  logic                sync_active,
    input  logic [REGION_W-1:0] region_pick,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [LEVEL_W-1:0]  led_level,
    input  logic                lang_pin,
    input  logic                fmt_pin,
    input  logic                reset_drive,
    input  logic [1:0]          sync_request,
    input  logic                status_valid,
    input  logic [REGION_W-1:0] active_region,
    input  logic [REGION_W-1:0] chosen_region,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [BREATHE_W-1:0] BREATHE_FOLD = 10'd512;

    typedef struct packed {
        logic [LEVEL_W-1:0]  led;
        logic                lang;
        logic                fmt;
        logic                rst_line;
        logic [1:0]          sreq;
        logic                status;
        logic [REGION_W-1:0] active;
        logic [REGION_W-1:0] chosen;
    } led_result_t;

    // Shadow copy of the configuration registers.
    logic [CFG_W-1:0]    cfg_long_press, cfg_sync_press, cfg_blink_dark, cfg_blink_lit;
    logic [CFG_W-1:0]    cfg_reset_hold;
    logic [LEVEL_W-1:0]  cfg_full_level;
    logic [MAP_W-1:0]    cfg_pin_map;
    logic [REGION_W-1:0] cfg_start;

    // Predicted controller state.
    logic [REGION_W-1:0] committed, selected;
    logic                sync_on, sync_req_sent, btn_prev, reset_active;
    logic [TIME_W-1:0]   press_t0, led_t0, reset_deadline;
    logic [1:0]          led_state;
    logic [BLINK_W-1:0]  blink_count;
    logic [LEVEL_W-1:0]  led_now;

    led_result_t expected_results[$];
    int          mismatch_total;

    // Choosing a region starts a blink sequence of region plus one flashes.
    function automatic void pick_region(input logic [REGION_W-1:0] r,
                                        input logic [TIME_W-1:0] t);
        selected    = r;
        led_state   = LED_BLINK;
        blink_count = BLINK_W'(r + 1);
        led_t0      = t;
    endfunction

    // Commit the chosen region and drive the console reset for the hold time.
    function automatic void pulse_reset(input logic [TIME_W-1:0] t);
        committed      = selected;
        reset_active   = 1'b1;
        reset_deadline = t + TIME_W'(cfg_reset_hold);
    endfunction

    // Advance the predicted state by one item and return its result.
    function automatic led_result_t next_result(input logic [CMD_W-1:0] c,
                                                input logic [TIME_W-1:0] t,
                                                input logic b,
                                                input logic sa,
                                                input logic [REGION_W-1:0] rp);
        led_result_t         r;
        logic [TIME_W-1:0]   diff, held, delta, limit, phase;
        logic [TIME_W-1:0]   period;
        logic [BREATHE_W-1:0] ramp;
        logic [MAP_W-1:0]    pins;

        r = '0;
        r.sreq = SREQ_NONE;

        // Reset pulse expires once the deadline is reached.
        diff = t - reset_deadline;
        if (reset_active && !diff[TIME_W-1])
            reset_active = 1'b0;

        // Button release and hold handling.
        if (btn_prev && !b) begin
            if (sync_on) begin
                r.sreq = SREQ_STOP;
            end
            else if (sync_req_sent) begin
                sync_req_sent = 1'b0;
            end
            else begin
                held = t - press_t0;
                if (held < TIME_W'(cfg_long_press))
                    pulse_reset(t);
                else
                    pick_region((selected >= REGION_W'(REGIONS - 1)) ? '0 : selected + 1'b1, t);
            end
        end
        else if (b) begin
            if (!btn_prev)
                press_t0 = t;
            held = t - press_t0;
            if (held > TIME_W'(cfg_sync_press) && !sync_req_sent) begin
                r.sreq = sync_on ? SREQ_STOP : SREQ_START;
                sync_req_sent = 1'b1;
            end
        end
        btn_prev = b;

        // LED waveform.
        if (led_state == LED_BLINK) begin
            period = TIME_W'(cfg_blink_dark) + TIME_W'(cfg_blink_lit);
            delta  = t - led_t0;
            limit  = period * TIME_W'(blink_count);
            if (delta > limit) begin
                led_state = sync_on ? LED_BREATHE : LED_STEADY;
                if (!sync_on)
                    led_now = cfg_full_level;
                blink_count = '0;
                led_t0      = t;
            end
            else begin
                phase   = (period != 0) ? delta % period : '0;
                led_now = (phase > TIME_W'(cfg_blink_dark)) ? cfg_full_level : '0;
            end
        end
        else if (led_state == LED_BREATHE) begin
            ramp = t[BREATHE_LSB +: BREATHE_W];
            if (ramp >= BREATHE_FOLD)
                ramp = BREATHE_MASK - ramp;
            ramp    = ramp >> 1;
            led_now = LEVEL_W'(ramp) * LEVEL_W'(ramp);
        end
        else begin
            led_state = LED_STEADY;
            led_now   = cfg_full_level;
        end

        // Host command; unused codes behave as a tick.
        case (c)
            CMD_SYNC: begin
                sync_on     = sa;
                led_state   = sa ? LED_BREATHE : LED_STEADY;
                blink_count = '0;
                led_t0      = t;
            end
            CMD_SELECT: begin
                if (rp < REGIONS)
                    pick_region(rp, t);
            end
            CMD_COMMIT: committed = selected;
            CMD_RESET:  pulse_reset(t);
            CMD_STATUS: r.status = 1'b1;
            default: ;
        endcase

        pins       = cfg_pin_map >> {committed, 1'b0};
        r.led      = led_now;
        r.lang     = pins[0];
        r.fmt      = pins[1];
        r.rst_line = reset_active;
        r.active   = committed;
        r.chosen   = selected;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatch_total++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        led_result_t want;
        if (!rst_n) begin
            cfg_long_press = RST_LONG_PRESS;
            cfg_sync_press = RST_SYNC_PRESS;
            cfg_blink_dark = RST_BLINK_DARK;
            cfg_blink_lit  = RST_BLINK_LIT;
            cfg_reset_hold = RST_RESET_HOLD;
            cfg_full_level = RST_FULL_LEVEL;
            cfg_pin_map    = RST_PIN_MAP;
            cfg_start      = RST_START;
            committed      = (RST_START < REGIONS) ? RST_START : '0;
            selected       = committed;
            sync_on        = 1'b0;
            sync_req_sent  = 1'b0;
            btn_prev       = 1'b0;
            reset_active   = 1'b0;
            press_t0       = '0;
            led_t0         = '0;
            reset_deadline = '0;
            led_state      = LED_STEADY;
            blink_count    = '0;
            led_now        = RST_FULL_LEVEL;
            expected_results.delete();
            mismatch_total = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else begin
            // Result transfer: compare against the oldest prediction.
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_total++;
                    $display("%0t: result transfer with no prediction waiting, actual led %0h",
                             $time, led_level);
                end
                else begin
                    want = expected_results.pop_front();
                    check_field("led_level", want.led, led_level);
                    check_field("lang_pin", want.lang, lang_pin);
                    check_field("fmt_pin", want.fmt, fmt_pin);
                    check_field("reset_drive", want.rst_line, reset_drive);
                    check_field("sync_request", want.sreq, sync_request);
                    check_field("status_valid", want.status, status_valid);
                    check_field("active_region", want.active, active_region);
                    check_field("chosen_region", want.chosen, chosen_region);
                end
            end

            // Register write transfer.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LONG_PRESS: cfg_long_press = cfg_data;
                    CFG_SYNC_PRESS: cfg_sync_press = cfg_data;
                    CFG_BLINK_DARK: cfg_blink_dark = cfg_data;
                    CFG_BLINK_LIT:  cfg_blink_lit  = cfg_data;
                    CFG_RESET_HOLD: cfg_reset_hold = cfg_data;
                    CFG_FULL_LEVEL: cfg_full_level = cfg_data[LEVEL_W-1:0];
                    CFG_PIN_MAP:    cfg_pin_map    = cfg_data[MAP_W-1:0];
                    CFG_START: begin
                        cfg_start = cfg_data[REGION_W-1:0];
                        committed = (cfg_start < REGIONS) ? cfg_start : '0;
                        selected  = committed;
                    end
                    default: ;
                endcase
            end

            // Item transfer: predict its result.
            if (in_valid && in_ready)
                expected_results.push_back(next_result(cmd, time_us, button_down,
                                                       sync_active, region_pick));

            pending    <= expected_results.size();
            fail_count <= mismatch_total;
        end
    end

endmodule

[tb/tb.sv]
// Top of the region switch LED controller testbench: clock, reset, register
// programming, item stimulus with bursts and result stalls, and the verdict.
// Depends on rsl_pkg, region_switch_led_controller_top and the checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsl_pkg::*;

    localparam int RESET_CYCLES  = 11;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 50;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 152;
    localparam int REG_COUNT     = 8;

    // Command codes without a function; the block treats them as a tick.
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [CMD_W-1:0]    cmd = CMD_TICK;
    logic [TIME_W-1:0]   time_us = '0;
    logic                button_down = 1'b0;
    logic                sync_active = 1'b0;
    logic [REGION_W-1:0] region_pick = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [LEVEL_W-1:0]  led_level;
    logic                lang_pin;
    logic                fmt_pin;
    logic                reset_drive;
    logic [1:0]          sync_request;
    logic                status_valid;
    logic [REGION_W-1:0] active_region;
    logic [REGION_W-1:0] chosen_region;
    int                  fail_count;
    int                  pending;

    // Stimulus bookkeeping.
    logic [TIME_W-1:0]   now_us = '0;
    logic [CFG_W-1:0]    reg_plan [REG_COUNT];
    logic [31:0]         long_us = 32'(RST_LONG_PRESS);
    logic [31:0]         sync_us = 32'(RST_SYNC_PRESS);
    logic [31:0]         span_us = 32'(RST_BLINK_DARK) + 32'(RST_BLINK_LIT);
    logic [31:0]         hold_us = 32'(RST_RESET_HOLD);
    int                  burst_left = 0;
    int                  sent_items = 0;

    region_switch_led_controller_top dut (.*);

    region_switch_led_checker checker_inst (.*);

    initial begin
        forever #5 clk = ~clk;
    end

    // Weighted command choice; tick_weight is the percentage of plain ticks.
    function automatic logic [CMD_W-1:0] pick_cmd(input int tick_weight);
        if ($urandom_range(0, 99) < tick_weight)
            return CMD_TICK;
        case ($urandom_range(0, 12))
            0, 1:    return CMD_SYNC;
            2, 3, 4: return CMD_SELECT;
            5, 6:    return CMD_COMMIT;
            7, 8:    return CMD_RESET;
            9, 10:   return CMD_STATUS;
            11:      return CMD_SPARE6;
            default: return CMD_SPARE7;
        endcase
    endfunction

    // Offer one item dt microseconds after the previous one and wait for its
    // transfer. The sender works in bursts with random gaps in between.
    task automatic send_sample(input logic [CMD_W-1:0] c, input logic [31:0] dt,
                               input logic b, input logic sa,
                               input logic [REGION_W-1:0] rp);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        now_us       = now_us + dt;
        in_valid    <= 1'b1;
        cmd         <= c;
        time_us     <= now_us;
        button_down <= b;
        sync_active <= sa;
        region_pick <= rp;
        do @(posedge clk); while (!in_ready);
        sent_items++;
    endtask

    // Stop offering items until every predicted result has come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: stalls on a pattern of segments, with an occasional long
    // hold-off so that the block backs up into its input.
    initial begin : receiver
        int seg;
        int len;
        int kind;
        seg = 0;
        forever begin
            kind = $urandom_range(0, 99);
            if (seg == 30 || kind == 0) begin
                len = $urandom_range(300, 600);
                repeat (len) begin
                    out_ready <= 1'b0;
                    @(posedge clk);
                end
            end
            else if (kind < 40) begin
                len = $urandom_range(10, 80);
                repeat (len) begin
                    out_ready <= 1'b1;
                    @(posedge clk);
                end
            end
            else if (kind < 80) begin
                len = $urandom_range(10, 60);
                repeat (len) begin
                    out_ready <= ($urandom_range(0, 1) == 1);
                    @(posedge clk);
                end
            end
            else begin
                len = $urandom_range(1, 15);
                repeat (len) begin
                    out_ready <= 1'b0;
                    @(posedge clk);
                end
            end
            seg++;
        end
    end

    // Watchdog: too many cycles without any transfer ends the run.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb failed");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] target;
        logic [31:0] step;
        logic [31:0] dt;
        int          held_n;
        int          mode;
        int          phase_start;
        int          roll;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset configuration.
        send_sample(CMD_TICK,   32'd0,       1'b0, 1'b0, 2'd0);
        send_sample(CMD_STATUS, 32'd10,      1'b0, 1'b1, 2'd3);
        // Out of range pick is ignored, then region two starts three blinks.
        send_sample(CMD_SELECT, 32'd10,      1'b0, 1'b0, 2'd3);
        send_sample(CMD_SELECT, 32'd10,      1'b0, 1'b0, 2'd2);
        // Dark edge of the phase, first lit sample, end of the last blink.
        send_sample(CMD_TICK,   32'd150000,  1'b0, 1'b0, 2'd0);
        send_sample(CMD_TICK,   32'd1,       1'b0, 1'b0, 2'd0);
        send_sample(CMD_TICK,   32'd749999,  1'b0, 1'b0, 2'd0);
        send_sample(CMD_TICK,   32'd1,       1'b0, 1'b0, 2'd0);
        send_sample(CMD_COMMIT, 32'd5,       1'b0, 1'b0, 2'd0);
        // Reset retriggered before it expires, then its exact expiry.
        send_sample(CMD_RESET,  32'd5,       1'b0, 1'b0, 2'd0);
        send_sample(CMD_RESET,  32'd50000,   1'b0, 1'b0, 2'd0);
        send_sample(CMD_TICK,   32'd99999,   1'b0, 1'b0, 2'd0);
        send_sample(CMD_TICK,   32'd1,       1'b0, 1'b0, 2'd0);
        // Breathing while a sync runs; a release then asks for a stop.
        send_sample(CMD_SYNC,   32'd10,      1'b0, 1'b1, 2'd0);
        send_sample(CMD_TICK,   32'd300000,  1'b1, 1'b0, 2'd0);
        send_sample(CMD_TICK,   32'd20,      1'b0, 1'b0, 2'd0);
        send_sample(CMD_SYNC,   32'd10,      1'b0, 1'b0, 2'd1);
        // Hold exactly at the sync time, one past it, then a swallowed release.
        send_sample(CMD_TICK,   32'd10,      1'b1, 1'b0, 2'd0);
        send_sample(CMD_TICK,   32'd3000000, 1'b1, 1'b0, 2'd0);
        send_sample(CMD_TICK,   32'd1,       1'b1, 1'b0, 2'd0);
        send_sample(CMD_TICK,   32'd10,      1'b0, 1'b0, 2'd0);
        // Release exactly at the long press time advances the region.
        send_sample(CMD_TICK,   32'd10,      1'b1, 1'b0, 2'd0);
        send_sample(CMD_TICK,   32'd1000000, 1'b0, 1'b0, 2'd0);
        // Short press with the spare command codes resets the console.
        send_sample(CMD_SPARE7, 32'd10,      1'b1, 1'b1, 2'd1);
        send_sample(CMD_SPARE6, 32'd999999,  1'b0, 1'b0, 2'd2);
        // Reset hold that wraps the timestamp.
        now_us = 32'hFFFF_FFF0;
        send_sample(CMD_RESET,  32'd0,       1'b0, 1'b0, 2'd0);
        send_sample(CMD_STATUS, 32'd100000,  1'b0, 1'b1, 2'd0);

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();

            // Pick the register setting for this phase.
            case (phase)
                0: begin
                    reg_plan[CFG_LONG_PRESS] = 24'd0;
                    reg_plan[CFG_SYNC_PRESS] = 24'd0;
                    reg_plan[CFG_BLINK_DARK] = 24'd1;
                    reg_plan[CFG_BLINK_LIT]  = 24'd0;
                    reg_plan[CFG_RESET_HOLD] = 24'd0;
                    reg_plan[CFG_FULL_LEVEL] = 24'hFF0000;
                    reg_plan[CFG_PIN_MAP]    = 24'hFFFFC0;
                    reg_plan[CFG_START]      = 24'h000003;
                end
                1: begin
                    for (int i = 0; i < REG_COUNT; i++)
                        reg_plan[IDX_W'(i)] = 24'hFFFFFF;
                    reg_plan[CFG_START] = 24'hFFFFFE;
                end
                2: begin
                    reg_plan[CFG_LONG_PRESS] = RST_LONG_PRESS;
                    reg_plan[CFG_SYNC_PRESS] = RST_SYNC_PRESS;
                    reg_plan[CFG_BLINK_DARK] = RST_BLINK_DARK;
                    reg_plan[CFG_BLINK_LIT]  = RST_BLINK_LIT;
                    reg_plan[CFG_RESET_HOLD] = RST_RESET_HOLD;
                    reg_plan[CFG_FULL_LEVEL] = CFG_W'(RST_FULL_LEVEL);
                    reg_plan[CFG_PIN_MAP]    = CFG_W'(RST_PIN_MAP);
                    reg_plan[CFG_START]      = CFG_W'(2'd1);
                end
                default: begin
                    reg_plan[CFG_LONG_PRESS] = CFG_W'($urandom_range(0, 4000));
                    reg_plan[CFG_SYNC_PRESS] = CFG_W'($urandom_range(0, 10000));
                    reg_plan[CFG_BLINK_DARK] = CFG_W'($urandom_range(1, 3000));
                    reg_plan[CFG_BLINK_LIT]  = CFG_W'($urandom_range(0, 3000));
                    reg_plan[CFG_RESET_HOLD] = CFG_W'($urandom_range(0, 5000));
                    // Upper bits beyond the register width are noise.
                    reg_plan[CFG_FULL_LEVEL] = CFG_W'($urandom);
                    reg_plan[CFG_PIN_MAP]    = CFG_W'($urandom);
                    reg_plan[CFG_START]      = CFG_W'($urandom);
                end
            endcase
            long_us = 32'(reg_plan[CFG_LONG_PRESS]);
            sync_us = 32'(reg_plan[CFG_SYNC_PRESS]);
            span_us = 32'(reg_plan[CFG_BLINK_DARK]) + 32'(reg_plan[CFG_BLINK_LIT]);
            hold_us = 32'(reg_plan[CFG_RESET_HOLD]);

            // One register write transfer per register, back to back.
            for (int i = 0; i < REG_COUNT; i++) begin
                cfg_valid <= 1'b1;
                cfg_index <= IDX_W'(i);
                cfg_data  <= reg_plan[IDX_W'(i)];
                do @(posedge clk); while (!cfg_ready);
            end
            cfg_valid <= 1'b0;

            // Some phases start just short of the timestamp wrap.
            if ($urandom_range(0, 3) == 0)
                now_us = 32'hFFFF_FFFF - $urandom_range(0, 4 * span_us + 16);

            phase_start = sent_items;
            while (sent_items - phase_start < PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    now_us = $urandom;
                if (roll < 55) begin
                    // Press sequence: press, held samples, release after target.
                    mode = $urandom_range(0, 9);
                    if (mode < 3) begin
                        held_n = 0;
                        target = long_us + $urandom_range(0, 2);
                        if (target != 0)
                            target = target - 1;
                    end
                    else if (mode < 5) begin
                        held_n = 1;
                        target = 2 * (sync_us + $urandom_range(0, 2));
                        if (target >= 2)
                            target = target - 2;
                    end
                    else if (mode < 8) begin
                        held_n = $urandom_range(0, 6);
                        target = $urandom_range(0, 2 * long_us + 2);
                    end
                    else begin
                        held_n = $urandom_range(0, 8);
                        target = $urandom_range(0, 2 * sync_us + 2);
                    end
                    step = target / (held_n + 1);
                    send_sample(pick_cmd(75), $urandom_range(0, span_us), 1'b1,
                                1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
                    repeat (held_n)
                        send_sample(pick_cmd(75), step, 1'b1,
                                    1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
                    send_sample(pick_cmd(75), target - step * held_n, 1'b0,
                                1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
                end
                else begin
                    // Run of samples with the button up at varied spacing.
                    repeat ($urandom_range(1, 6)) begin
                        case ($urandom_range(0, 3))
                            0:       dt = $urandom_range(0, span_us / 2 + 1);
                            1:       dt = $urandom_range(0, 3 * span_us + 1);
                            2:       dt = $urandom_range(0, hold_us + 2);
                            default: dt = $urandom_range(0, 4096);
                        endcase
                        send_sample(pick_cmd(40), dt, 1'b0,
                                    1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
                    end
                end
            end
        end

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
